/* src/btfd_pkg.sv */
// shared types, constants and match codes of the bus trace fetch detector
package btfd_pkg;

	// window geometry and field widths
	localparam int WinDepth = 4;
	localparam int AddrW    = 16;
	localparam int DataW    = 8;
	localparam int CntW     = $clog2(WinDepth + 1);
	localparam int KindW    = 3;

	// opcode patterns
	localparam logic [DataW-1:0] BranchMask  = 8'h1B;
	localparam logic [DataW-1:0] BranchValue = 8'h64;
	localparam logic [DataW-1:0] JumpOpcode  = 8'h24;

	// match kinds
	localparam logic [KindW-1:0] KindNone    = 3'd0;
	localparam logic [KindW-1:0] KindEight   = 3'd1;
	localparam logic [KindW-1:0] KindSixteen = 3'd2;
	localparam logic [KindW-1:0] KindRmw     = 3'd3;
	localparam logic [KindW-1:0] KindBranch  = 3'd4;
	localparam logic [KindW-1:0] KindJump    = 3'd5;

	// one observed bus cycle as held in the window
	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [DataW-1:0] data;
		logic             rd;
	} slot_t;

	typedef slot_t [WinDepth-1:0] window_t;

endpackage

/* src/bus_trace_fetch_detector.sv */
// top level: window cell chain, pattern matcher and output skid stage
// Takes one bus cycle word per clock while in_stall is low and returns one result
// word per input word, registered in the output register when the output side is free.
// The matcher is a single level of 17/18-bit adds and compares between the four-cell
// window and the output register; a two-entry output stage (result register plus skid
// register) drives a registered in_stall, so input keeps flowing at one word per clock
// while the downstream side takes words. Results are judged only after four words have
// entered the window; earlier words report no fetch.
module bus_trace_fetch_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [btfd_pkg::AddrW-1:0]    address,
	input  logic [btfd_pkg::DataW-1:0]    data_byte,
	input  logic                          is_read,
	input  logic                          device_selected,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          fetch_detected,
	output logic [btfd_pkg::KindW-1:0]    match_kind
);

	localparam logic [btfd_pkg::CntW-1:0] CntFull = btfd_pkg::CntW'(btfd_pkg::WinDepth);

	logic                           in_accept;
	logic                           out_move;
	btfd_pkg::slot_t                cur_slot;
	btfd_pkg::window_t              win;
	logic [btfd_pkg::KindW-1:0]     raw_kind;
	logic [btfd_pkg::KindW-1:0]     new_kind;
	logic [btfd_pkg::CntW-1:0]      cycles_seen_q;
	logic                           out_valid_q;
	logic [btfd_pkg::KindW-1:0]     out_kind_q;
	logic                           skid_valid_q;
	logic [btfd_pkg::KindW-1:0]     skid_kind_q;

	assign in_accept = in_valid && !in_stall;
	assign out_move  = out_valid_q && !out_stall;
	assign cur_slot  = '{addr: address, data: data_byte, rd: is_read};

	// window chain, newest cell at the top index
	for (genvar i = 0; i < btfd_pkg::WinDepth; i++) begin : g_cell
		btfd_pkg::slot_t cell_in;
		if (i == btfd_pkg::WinDepth - 1) begin : g_head
			assign cell_in = cur_slot;
		end else begin : g_body
			assign cell_in = win[i+1];
		end
		btfd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (in_accept),
			.din    (cell_in),
			.dout   (win[i])
		);
	end

	// pattern matching on the current word
	btfd_judge u_judge (
		.win  (win),
		.cur  (address),
		.kind (raw_kind)
	);

	assign new_kind = ((cycles_seen_q == CntFull) && is_read && !device_selected)
	                ? raw_kind : btfd_pkg::KindNone;

	// saturating fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_seen_q <= '0;
		end else if (in_accept && (cycles_seen_q != CntFull)) begin
			cycles_seen_q <= cycles_seen_q + 1'b1;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_move) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_accept) begin
			if (!out_valid_q || out_move) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_move) begin
			out_valid_q <= 1'b0;
		end
	end

	// result words, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_move) begin
				out_kind_q <= skid_kind_q;
			end
		end else if (in_accept) begin
			if (!out_valid_q || out_move) begin
				out_kind_q <= new_kind;
			end else begin
				skid_kind_q <= new_kind;
			end
		end
	end

	assign in_stall       = skid_valid_q;
	assign out_valid      = out_valid_q;
	assign match_kind     = out_kind_q;
	assign fetch_detected = (out_kind_q != btfd_pkg::KindNone);

	// skid entry only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without a result in the output register");

	// fill counter never passes the window depth
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cycles_seen_q <= CntFull)
		else $error("fill counter beyond window depth");

	// an accepted word into an empty output stage shows up next cycle
	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("accepted word did not reach the output register");

	// no fetch reported before the window has filled
	a_no_early_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !out_valid_q && (cycles_seen_q != CntFull)) |=> (out_kind_q == btfd_pkg::KindNone))
		else $error("fetch reported before window full");

endmodule

/* src/btfd_cell.sv */
// one window cell: holds a bus cycle and passes it to the older neighbor
module btfd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  btfd_pkg::slot_t din,
	output btfd_pkg::slot_t dout
);

	btfd_pkg::slot_t slot_q;

	// take the newer neighbor's word on every accepted cycle, window clears to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= din;
		end
	end

	assign dout = slot_q;

endmodule

/* src/btfd_judge.sv */
// pattern matcher: classifies the current address against the window
module btfd_judge (
	input  btfd_pkg::window_t                win,
	input  logic [btfd_pkg::AddrW-1:0]       cur,
	output logic [btfd_pkg::KindW-1:0]       kind
);

	// address plus one, one bit wider so nothing wraps
	function automatic logic [btfd_pkg::AddrW:0] inc(input logic [btfd_pkg::AddrW-1:0] a);
		return {1'b0, a} + {{btfd_pkg::AddrW{1'b0}}, 1'b1};
	endfunction

	logic [btfd_pkg::AddrW:0]   cur_x;
	logic [btfd_pkg::AddrW+1:0] br_target;
	logic [btfd_pkg::AddrW:0]   jmp_target;
	logic [btfd_pkg::AddrW:0]   a1_plus2;
	logic                       eight_hit;
	logic                       base16;
	logic                       sixteen_hit;
	logic                       rmw_hit;
	logic                       branch_hit;
	logic                       jump_hit;

	// widened sums for branch and jump targets
	assign cur_x      = {1'b0, cur};
	assign br_target  = {2'b00, win[3].addr}
	                  + {{(btfd_pkg::AddrW + 2 - btfd_pkg::DataW){win[3].data[btfd_pkg::DataW-1]}},
	                     win[3].data}
	                  + {{(btfd_pkg::AddrW + 1){1'b0}}, 1'b1};
	assign jmp_target = {1'b0, win[3].data, win[2].data} + {{btfd_pkg::AddrW{1'b0}}, 1'b1};
	assign a1_plus2   = {1'b0, win[1].addr} + {{(btfd_pkg::AddrW - 1){1'b0}}, 2'd2};

	// individual patterns
	assign eight_hit = (cur_x == inc(win[2].addr)) && ({1'b0, win[2].addr} == inc(win[1].addr))
	                && win[1].rd && win[2].rd;
	assign base16    = (cur_x == inc(win[1].addr)) && ({1'b0, win[1].addr} == inc(win[0].addr))
	                && win[0].rd && win[1].rd;
	assign sixteen_hit = base16 && ({1'b0, win[3].addr} == inc(win[2].addr))
	                  && (win[2].rd == win[3].rd);
	assign rmw_hit   = base16 && (win[3].addr == win[2].addr) && win[2].rd && !win[3].rd;
	assign branch_hit = win[2].rd && ((win[2].data & ~btfd_pkg::BranchMask) == btfd_pkg::BranchValue)
	                 && ({1'b0, win[3].addr} == inc(win[2].addr)) && win[3].rd
	                 && ({1'b0, cur_x} == br_target);
	assign jump_hit  = win[1].rd && (win[1].data == btfd_pkg::JumpOpcode)
	                && ({1'b0, win[2].addr} == inc(win[1].addr))
	                && ({1'b0, win[3].addr} == a1_plus2) && win[2].rd && win[3].rd
	                && (cur_x == jmp_target);

	// priority select
	always_comb begin
		if (eight_hit) begin
			kind = btfd_pkg::KindEight;
		end else if (sixteen_hit) begin
			kind = btfd_pkg::KindSixteen;
		end else if (rmw_hit) begin
			kind = btfd_pkg::KindRmw;
		end else if (branch_hit) begin
			kind = btfd_pkg::KindBranch;
		end else if (jump_hit) begin
			kind = btfd_pkg::KindJump;
		end else begin
			kind = btfd_pkg::KindNone;
		end
	end

endmodule
